// ===== rtl/kpt_pkg.sv =====
package kpt_pkg;

   localparam int CAPACITY_DEF   = 16;
   localparam int COORD_BITS_DEF = 16;
   localparam int OP_W           = 3;
   localparam int LIMIT_W        = 5;
   localparam int REV_W          = 32;
   localparam int URG_W          = 16;
   // depth of the dx, sq and score registers between a new center and a settled score in every cell
   localparam int SCORE_LAT      = 3;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE  = 3'd0,
      OP_CONTAINS = 3'd1,
      OP_REMOVE   = 3'd2,
      OP_CLEAR    = 3'd3,
      OP_POP      = 3'd4
   } kpt_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCORE,
      ST_SCAN,
      ST_EMIT
   } kpt_state_type;

   typedef struct packed {
      logic wr_en;
      logic kill;
      logic clear_all;
   } kpt_cell_ctrl_type;

endpackage

// ===== rtl/keyed_priority_table_pop_closest.sv =====
// table operations register the request, then load their result once the output is free
// pop: ST_SCORE lets the cell scores settle, then an ST_SCAN pass and an ST_EMIT per emitted entry
//   (the best-candidate token walks the whole cell chain once per entry)
// throughput: one item at a time, next item taken once the last result is loaded
// reset clears all slot valid bits, occupancy and handshake state
module keyed_priority_table_pop_closest
   import kpt_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [OP_W-1:0]               req_opcode,
   input  logic signed [COORD_BITS-1:0]  req_key_x,
   input  logic signed [COORD_BITS-1:0]  req_key_y,
   input  logic signed [COORD_BITS-1:0]  req_key_z,
   input  logic [REV_W-1:0]              req_data_revision,
   input  logic [REV_W-1:0]              req_built_revision,
   input  logic signed [URG_W-1:0]       req_urgency,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic signed [COORD_BITS-1:0]  req_center_z,
   input  logic [LIMIT_W-1:0]            req_pop_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic                          rsp_rejected_full,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   output logic signed [COORD_BITS-1:0]  rsp_out_z,
   output logic [REV_W-1:0]              rsp_out_revision,
   output logic [REV_W-1:0]              rsp_out_mesh_revision,
   output logic signed [URG_W-1:0]       rsp_out_urgency,
   output logic                          rsp_entry_valid,
   output logic                          rsp_last,
   output logic [$clog2(CAPACITY+1)-1:0] rsp_occupancy
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = 2*COORD_BITS + 3;

   kpt_state_type state_ff, state_in;

   logic [OP_W-1:0]              op_ff;
   logic signed [COORD_BITS-1:0] kx_ff, ky_ff, kz_ff, cx_ff, cy_ff, cz_ff;
   logic [REV_W-1:0]             rev_ff, mrev_ff;
   logic signed [URG_W-1:0]      urg_ff;
   logic [LIMIT_W-1:0]           limit_ff;

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic [CW-1:0] occ_ff, occ_in;

   logic                         out_vld_ff, out_vld_in;
   logic                         out_hit_ff, out_hit_in;
   logic                         out_rej_ff, out_rej_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in, out_z_ff, out_z_in;
   logic [REV_W-1:0]             out_rev_ff, out_rev_in, out_mrev_ff, out_mrev_in;
   logic signed [URG_W-1:0]      out_urg_ff, out_urg_in;
   logic                         out_ent_ff, out_ent_in;
   logic                         out_last_ff, out_last_in;
   logic [CW-1:0]                out_occ_ff, out_occ_in;
   logic                         load_out;

   kpt_cell_ctrl_type            cell_ctrl [CAPACITY];
   logic [CAPACITY-1:0]          valid_vec, match_vec;
   logic [REV_W-1:0]             cell_rev [CAPACITY];
   logic [REV_W-1:0]             cell_mrev [CAPACITY];

   logic                         tok_vld   [CAPACITY+1];
   logic signed [URG_W-1:0]      tok_urg   [CAPACITY+1];
   logic [SW-1:0]                tok_score [CAPACITY+1];
   logic signed [COORD_BITS-1:0] tok_x     [CAPACITY+1];
   logic signed [COORD_BITS-1:0] tok_y     [CAPACITY+1];
   logic signed [COORD_BITS-1:0] tok_z     [CAPACITY+1];
   logic [IW-1:0]                tok_idx   [CAPACITY+1];

   logic          req_xfer, out_free;
   logic          any_match, any_free;
   logic [IW-1:0] match_idx, free_idx, win_idx;
   logic [7:0]    lim8, n8;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !out_vld_ff || !rsp_stall;

   // chain head injects an empty token
   assign tok_vld[0]   = 1'b0;
   assign tok_urg[0]   = '0;
   assign tok_score[0] = '0;
   assign tok_x[0]     = '0;
   assign tok_y[0]     = '0;
   assign tok_z[0]     = '0;
   assign tok_idx[0]   = '0;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      kpt_cell #(
         .COORD_BITS (COORD_BITS),
         .IW         (IW),
         .CELL_IDX   (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .key_x      (kx_ff),
         .key_y      (ky_ff),
         .key_z      (kz_ff),
         .wr_rev     (rev_ff),
         .wr_mrev    (mrev_ff),
         .wr_urg     (urg_ff),
         .cen_x      (cx_ff),
         .cen_y      (cy_ff),
         .cen_z      (cz_ff),
         .tin_vld    (tok_vld[g]),
         .tin_urg    (tok_urg[g]),
         .tin_score  (tok_score[g]),
         .tin_x      (tok_x[g]),
         .tin_y      (tok_y[g]),
         .tin_z      (tok_z[g]),
         .tin_idx    (tok_idx[g]),
         .tout_vld   (tok_vld[g+1]),
         .tout_urg   (tok_urg[g+1]),
         .tout_score (tok_score[g+1]),
         .tout_x     (tok_x[g+1]),
         .tout_y     (tok_y[g+1]),
         .tout_z     (tok_z[g+1]),
         .tout_idx   (tok_idx[g+1]),
         .valid_o    (valid_vec[g]),
         .match_o    (match_vec[g]),
         .rev_o      (cell_rev[g]),
         .mrev_o     (cell_mrev[g])
      );
   end

   assign win_idx = tok_idx[CAPACITY];

   // keys are unique, so at most one match bit is set
   always_comb begin
      any_match = |match_vec;
      match_idx = '0;
      any_free  = 1'b0;
      free_idx  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match_vec[i]) begin
            match_idx = match_idx | IW'(i);
         end
      end
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_vec[i]) begin
            any_free = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   always_comb begin
      lim8 = {{(8-LIMIT_W){1'b0}}, limit_ff};
      if (lim8 > 8'(CAPACITY)) begin
         lim8 = 8'(CAPACITY);
      end
      n8 = (lim8 < 8'(occ_ff)) ? lim8 : 8'(occ_ff);
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      remain_in   = remain_ff;
      occ_in      = occ_ff;
      load_out    = 1'b0;
      out_hit_in  = 1'b0;
      out_rej_in  = 1'b0;
      out_x_in    = '0;
      out_y_in    = '0;
      out_z_in    = '0;
      out_rev_in  = '0;
      out_mrev_in = '0;
      out_urg_in  = '0;
      out_ent_in  = 1'b0;
      out_last_in = 1'b1;
      out_occ_in  = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ctrl[i] = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               load_out = 1'b1;
               unique case (op_ff)
                  OP_ENQUEUE: begin
                     if (any_match) begin
                        cell_ctrl[match_idx].wr_en = 1'b1;
                     end else if (any_free) begin
                        cell_ctrl[free_idx].wr_en = 1'b1;
                        out_hit_in = 1'b1;
                        occ_in     = occ_ff + 1'b1;
                     end else begin
                        out_rej_in = 1'b1;
                     end
                  end
                  OP_CONTAINS: begin
                     out_hit_in = any_match;
                  end
                  OP_REMOVE: begin
                     if (any_match) begin
                        cell_ctrl[match_idx].kill = 1'b1;
                        occ_in = occ_ff - 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     for (int i = 0; i < CAPACITY; i++) begin
                        cell_ctrl[i].clear_all = 1'b1;
                     end
                     occ_in = '0;
                  end
                  OP_POP: begin
                     if (n8 != 8'd0) begin
                        load_out  = 1'b0;
                        state_in  = ST_SCORE;
                        cnt_in    = '0;
                        remain_in = CW'(n8);
                        occ_in    = occ_ff - CW'(n8);
                     end
                  end
                  default: begin
                  end
               endcase
               out_occ_in = occ_in;
            end
         end
         ST_SCORE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SCORE_LAT - 1)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(CAPACITY - 1)) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out    = 1'b1;
               out_x_in    = tok_x[CAPACITY];
               out_y_in    = tok_y[CAPACITY];
               out_z_in    = tok_z[CAPACITY];
               out_urg_in  = tok_urg[CAPACITY];
               out_rev_in  = cell_rev[win_idx];
               out_mrev_in = cell_mrev[win_idx];
               out_ent_in  = 1'b1;
               out_last_in = (remain_ff == CW'(1));
               cell_ctrl[win_idx].kill = 1'b1;
               remain_in   = remain_ff - 1'b1;
               state_in    = (remain_ff == CW'(1)) ? ST_IDLE : ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         out_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         remain_ff  <= '0;
         occ_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         remain_ff  <= remain_in;
         occ_ff     <= occ_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_opcode;
         kx_ff    <= req_key_x;
         ky_ff    <= req_key_y;
         kz_ff    <= req_key_z;
         rev_ff   <= req_data_revision;
         mrev_ff  <= req_built_revision;
         urg_ff   <= req_urgency;
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         cz_ff    <= req_center_z;
         limit_ff <= req_pop_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_hit_ff  <= out_hit_in;
         out_rej_ff  <= out_rej_in;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
         out_z_ff    <= out_z_in;
         out_rev_ff  <= out_rev_in;
         out_mrev_ff <= out_mrev_in;
         out_urg_ff  <= out_urg_in;
         out_ent_ff  <= out_ent_in;
         out_last_ff <= out_last_in;
         out_occ_ff  <= out_occ_in;
      end
   end

   assign rsp_valid             = out_vld_ff;
   assign rsp_hit               = out_hit_ff;
   assign rsp_rejected_full     = out_rej_ff;
   assign rsp_out_x             = out_x_ff;
   assign rsp_out_y             = out_y_ff;
   assign rsp_out_z             = out_z_ff;
   assign rsp_out_revision      = out_rev_ff;
   assign rsp_out_mesh_revision = out_mrev_ff;
   assign rsp_out_urgency       = out_urg_ff;
   assign rsp_entry_valid       = out_ent_ff;
   assign rsp_last              = out_last_ff;
   assign rsp_occupancy         = out_occ_ff;

   a_occ_matches: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (occ_ff == CW'($countones(valid_vec))))
      else $error("occupancy count out of step with slot valid bits");

   a_emit_has_winner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> tok_vld[CAPACITY])
      else $error("pop emit without a winning entry");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(CAPACITY))
      else $error("occupancy above capacity");

   a_emit_kills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> !valid_vec[$past(win_idx)])
      else $error("emitted entry still valid");

endmodule

// ===== rtl/kpt_cell.sv =====
module kpt_cell
   import kpt_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int IW         = 4,
   parameter int CELL_IDX   = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  kpt_cell_ctrl_type              ctrl,
   input  logic signed [COORD_BITS-1:0]   key_x,
   input  logic signed [COORD_BITS-1:0]   key_y,
   input  logic signed [COORD_BITS-1:0]   key_z,
   input  logic [REV_W-1:0]               wr_rev,
   input  logic [REV_W-1:0]               wr_mrev,
   input  logic signed [URG_W-1:0]        wr_urg,
   input  logic signed [COORD_BITS-1:0]   cen_x,
   input  logic signed [COORD_BITS-1:0]   cen_y,
   input  logic signed [COORD_BITS-1:0]   cen_z,
   input  logic                           tin_vld,
   input  logic signed [URG_W-1:0]        tin_urg,
   input  logic [2*COORD_BITS+2:0]        tin_score,
   input  logic signed [COORD_BITS-1:0]   tin_x,
   input  logic signed [COORD_BITS-1:0]   tin_y,
   input  logic signed [COORD_BITS-1:0]   tin_z,
   input  logic [IW-1:0]                  tin_idx,
   output logic                           tout_vld,
   output logic signed [URG_W-1:0]        tout_urg,
   output logic [2*COORD_BITS+2:0]        tout_score,
   output logic signed [COORD_BITS-1:0]   tout_x,
   output logic signed [COORD_BITS-1:0]   tout_y,
   output logic signed [COORD_BITS-1:0]   tout_z,
   output logic [IW-1:0]                  tout_idx,
   output logic                           valid_o,
   output logic                           match_o,
   output logic [REV_W-1:0]               rev_o,
   output logic [REV_W-1:0]               mrev_o
);

   localparam int SW = 2*COORD_BITS + 3;

   logic                          valid_ff;
   logic signed [COORD_BITS-1:0]  x_ff, y_ff, z_ff;
   logic [REV_W-1:0]              rev_ff, mrev_ff;
   logic signed [URG_W-1:0]       urg_ff;

   logic signed [COORD_BITS:0]    dx_ff, dy_ff, dz_ff;
   logic signed [2*COORD_BITS+1:0] sqx_ff, sqy_ff, sqz_ff;
   logic [SW-1:0]                 score_ff;

   logic                          tvld_ff;
   logic signed [URG_W-1:0]       turg_ff;
   logic [SW-1:0]                 tscore_ff;
   logic signed [COORD_BITS-1:0]  tx_ff, ty_ff, tz_ff;
   logic [IW-1:0]                 tidx_ff;

   logic own_first;
   logic take_own;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.clear_all || ctrl.kill) begin
         valid_ff <= 1'b0;
      end else if (ctrl.wr_en) begin
         valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         x_ff    <= key_x;
         y_ff    <= key_y;
         z_ff    <= key_z;
         rev_ff  <= wr_rev;
         mrev_ff <= wr_mrev;
         urg_ff  <= wr_urg;
      end
   end

   // free-running distance score, registered through the dx, sq and score stages after the center
   always_ff @(posedge clock) begin
      dx_ff    <= {x_ff[COORD_BITS-1], x_ff} - {cen_x[COORD_BITS-1], cen_x};
      dy_ff    <= {y_ff[COORD_BITS-1], y_ff} - {cen_y[COORD_BITS-1], cen_y};
      dz_ff    <= {z_ff[COORD_BITS-1], z_ff} - {cen_z[COORD_BITS-1], cen_z};
      sqx_ff   <= dx_ff * dx_ff;
      sqy_ff   <= dy_ff * dy_ff;
      sqz_ff   <= dz_ff * dz_ff;
      score_ff <= SW'($unsigned(sqx_ff)) + (SW'($unsigned(sqy_ff)) << 2)
                  + SW'($unsigned(sqz_ff));
   end

   always_comb begin
      if (urg_ff != tin_urg) begin
         own_first = urg_ff < tin_urg;
      end else if (score_ff != tin_score) begin
         own_first = score_ff < tin_score;
      end else if (y_ff != tin_y) begin
         own_first = y_ff < tin_y;
      end else if (x_ff != tin_x) begin
         own_first = x_ff < tin_x;
      end else begin
         own_first = z_ff < tin_z;
      end
      take_own = valid_ff && (!tin_vld || own_first);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tvld_ff <= 1'b0;
      end else begin
         tvld_ff <= take_own || tin_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (take_own) begin
         turg_ff   <= urg_ff;
         tscore_ff <= score_ff;
         tx_ff     <= x_ff;
         ty_ff     <= y_ff;
         tz_ff     <= z_ff;
         tidx_ff   <= IW'(CELL_IDX);
      end else begin
         turg_ff   <= tin_urg;
         tscore_ff <= tin_score;
         tx_ff     <= tin_x;
         ty_ff     <= tin_y;
         tz_ff     <= tin_z;
         tidx_ff   <= tin_idx;
      end
   end

   assign tout_vld   = tvld_ff;
   assign tout_urg   = turg_ff;
   assign tout_score = tscore_ff;
   assign tout_x     = tx_ff;
   assign tout_y     = ty_ff;
   assign tout_z     = tz_ff;
   assign tout_idx   = tidx_ff;
   assign valid_o    = valid_ff;
   assign match_o    = valid_ff && (x_ff == key_x) && (y_ff == key_y) && (z_ff == key_z);
   assign rev_o      = rev_ff;
   assign mrev_o     = mrev_ff;

endmodule
